// ----- rtl/skewed_four_way_block_cache_tags_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the skewed four-way block cache tag engine
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SKEWED_FOUR_WAY_BLOCK_CACHE_TAGS_MACROS_SVH
`define SKEWED_FOUR_WAY_BLOCK_CACHE_TAGS_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SKT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SKT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// Shared constants, hash multipliers and the controller-to-datapath command
// type of the skewed four-way block cache tag engine.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  // Number of ways and fixed field widths
  localparam int NWAYS     = 4;
  localparam int WAY_W     = 2;
  localparam int TID_W     = 10;
  localparam int POS_W     = 40;
  localparam int SIDX_W    = 10;
  localparam int OFF_W     = 16;
  localparam int CNT_W     = 32;

  // Default geometry (both must be powers of two)
  localparam int SETS_DEF        = 1024;
  localparam int BLOCK_BYTES_DEF = 65536;

  // Per-way hash multipliers: set = tab * table_id + blk * block_number
  localparam logic [9:0] MUL_TAB [NWAYS] = '{10'd123, 10'd179, 10'd671, 10'd773};
  localparam logic [9:0] MUL_BLK [NWAYS] = '{10'd321, 10'd557, 10'd409, 10'd187};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic rd_en;   // capture the lookup and read all four tag stores
    logic commit;  // resolve hit or victim, update tags, load the result
    logic clr_en;  // clear one set in every way
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/skt_ctrl.sv -----
// ----------------------------------------------------------------------------
// skt_ctrl
// Controller: runs the post-reset clearing pass, sequences each lookup
// through accept and commit, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ctrl #(
  parameter int SETS = skt_pkg::SETS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output skt_pkg::cmd_t                cmd_o,
  output logic [$clog2(SETS)-1:0]      clr_addr_o
);

  localparam int IDX_W = $clog2(SETS);
  localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(SETS - 1);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_LOOKUP = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] clr_addr_q, clr_addr_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             commit;

  // Take a transaction only when idle; commit once the output slot is free
  assign accept = in_valid_i && (state_q == S_IDLE);
  assign commit = (state_q == S_LOOKUP) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign clr_addr_o  = clr_addr_q;

  assign cmd_o.rd_en  = accept;
  assign cmd_o.commit = commit;
  assign cmd_o.clr_en = (state_q == S_CLEAR);

  // Advance the state and the clearing address
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    case (state_q)
      S_CLEAR: begin
        clr_addr_d = clr_addr_q + IDX_W'(1);
        if (clr_addr_q == LAST_SET) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // Set valid on commit, drop it once the result is taken
  assign out_valid_d = commit | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/skt_datapath.sv -----
// ----------------------------------------------------------------------------
// skt_datapath
// Datapath: per-way set hashing, four tag memories, tag compare, victim
// selection, the miss counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_datapath #(
  parameter int SETS        = skt_pkg::SETS_DEF,
  parameter int BLOCK_BYTES = skt_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire skt_pkg::cmd_t                     cmd_i,
  input  wire logic [$clog2(SETS)-1:0]           clr_addr_i,
  input  wire logic [skt_pkg::TID_W-1:0]         table_id_i,
  input  wire logic [skt_pkg::POS_W-1:0]         position_i,
  output logic                                   hit_o,
  output logic [skt_pkg::WAY_W-1:0]              way_o,
  output logic [skt_pkg::SIDX_W-1:0]             set_index_o,
  output logic [skt_pkg::OFF_W-1:0]              byte_offset_o
);

  localparam int NWAYS     = skt_pkg::NWAYS;
  localparam int IDX_W     = $clog2(SETS);
  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int BLK_W     = skt_pkg::POS_W - BLK_SHIFT;
  localparam int TAG_W     = skt_pkg::TID_W + BLK_W;
  localparam int MEM_W     = TAG_W + 1;

  logic [IDX_W-1:0]           tid_x;
  logic [IDX_W-1:0]           blk_x;
  logic [IDX_W-1:0]           idx_d [NWAYS];
  logic [IDX_W-1:0]           idx_q [NWAYS];
  logic [TAG_W-1:0]           tag_q;
  logic [BLK_SHIFT-1:0]       off_q;
  logic [MEM_W-1:0]           rdata_q [NWAYS];
  logic [NWAYS-1:0]           way_valid;
  logic [NWAYS-1:0]           way_match;
  logic                       hit;
  logic [skt_pkg::WAY_W-1:0]  hit_way;
  logic [skt_pkg::WAY_W-1:0]  empty_way;
  logic                       any_empty;
  logic [skt_pkg::WAY_W-1:0]  rr_way;
  logic [skt_pkg::WAY_W-1:0]  sel_way;
  logic [skt_pkg::CNT_W-1:0]  miss_cnt_q;
  logic [skt_pkg::CNT_W-1:0]  miss_cnt_inc;
  logic [4:0]                 ones_lo;
  logic [4:0]                 ones_hi;

  // Hash operands reduced to the index width (the hash is taken mod SETS)
  assign tid_x = IDX_W'(table_id_i);
  assign blk_x = position_i[BLK_SHIFT +: IDX_W];

  // Capture the lookup key
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      tag_q <= {table_id_i, position_i[skt_pkg::POS_W-1:BLK_SHIFT]};
      off_q <= position_i[BLK_SHIFT-1:0];
    end
  end

  // One tag memory per way, each with its own hash
  for (genvar w = 0; w < NWAYS; w++) begin : g_way
    logic [MEM_W-1:0] mem [SETS];
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [MEM_W-1:0] wr_data;

    assign idx_d[w] = IDX_W'(skt_pkg::MUL_TAB[w]) * tid_x
                    + IDX_W'(skt_pkg::MUL_BLK[w]) * blk_x;

    assign wr_en   = cmd_i.clr_en
                   | (cmd_i.commit & ~hit & (sel_way == skt_pkg::WAY_W'(w)));
    assign wr_addr = cmd_i.clr_en ? clr_addr_i : idx_q[w];
    assign wr_data = cmd_i.clr_en ? '0 : {1'b1, tag_q};

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
      if (cmd_i.rd_en) begin
        rdata_q[w] <= mem[idx_d[w]];
        idx_q[w]   <= idx_d[w];
      end
    end

    assign way_valid[w] = rdata_q[w][TAG_W];
    assign way_match[w] = way_valid[w] && (rdata_q[w][TAG_W-1:0] == tag_q);
  end

  // Pick the lowest matching way and the highest empty way
  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    any_empty = 1'b0;
    empty_way = '0;
    for (int w = NWAYS - 1; w >= 0; w--) begin
      if (way_match[w]) begin
        hit     = 1'b1;
        hit_way = skt_pkg::WAY_W'(w);
      end
    end
    for (int w = 0; w < NWAYS; w++) begin
      if (!way_valid[w]) begin
        any_empty = 1'b1;
        empty_way = skt_pkg::WAY_W'(w);
      end
    end
  end

  // Low two bits of sum(cnt >> s), s = 0..15: bit counts of two windows
  assign miss_cnt_inc = miss_cnt_q + skt_pkg::CNT_W'(1);
  assign ones_lo      = 5'($countones(miss_cnt_inc[15:0]));
  assign ones_hi      = 5'($countones(miss_cnt_inc[16:1]));
  assign rr_way       = ones_lo[1:0] + {ones_hi[0], 1'b0};

  always_comb begin
    if (hit) begin
      sel_way = hit_way;
    end else if (any_empty) begin
      sel_way = empty_way;
    end else begin
      sel_way = rr_way;
    end
  end

  // Count misses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_cnt_q <= '0;
    end else if (cmd_i.commit && !hit) begin
      miss_cnt_q <= miss_cnt_inc;
    end
  end

  // Load the result register on commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_o         <= hit;
      way_o         <= sel_way;
      set_index_o   <= skt_pkg::SIDX_W'(idx_q[sel_way]);
      byte_offset_o <= skt_pkg::OFF_W'(off_q);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/skewed_four_way_block_cache_tags.sv -----
// Skewed four-way block cache tag engine. Each transaction (table id,
// position) is looked up in four tag memories, one per way, each addressed by
// its own multiply-add hash of table id and block number; the result gives hit
// or allocation, the way, the set index and the byte offset in the block. The
// accept cycle issues the four memory reads into registers; the commit, taken
// once the output slot is free, compares the registered tags, picks the victim
// on a miss and writes it back. A new item is taken in the cycle after the
// commit, so the block takes no new item before the last one has committed.
// After reset the block clears its tag memories, one set of all four ways per
// cycle, stalling its input until every set is clear. SETS and BLOCK_BYTES must
// be powers of two.
// ----------------------------------------------------------------------------
// skewed_four_way_block_cache_tags
// Top level: joins the controller and the datapath and holds the checks.
// ----------------------------------------------------------------------------
`default_nettype none

`include "skewed_four_way_block_cache_tags_macros.svh"

module skewed_four_way_block_cache_tags #(
  parameter int SETS        = skt_pkg::SETS_DEF,
  parameter int BLOCK_BYTES = skt_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [skt_pkg::TID_W-1:0]   table_id_i,
  input  wire logic [skt_pkg::POS_W-1:0]   position_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             hit_o,
  output logic [skt_pkg::WAY_W-1:0]        way_o,
  output logic [skt_pkg::SIDX_W-1:0]       set_index_o,
  output logic [skt_pkg::OFF_W-1:0]        byte_offset_o
);

  localparam int IDX_W = $clog2(SETS);

  skt_pkg::cmd_t    cmd;
  logic [IDX_W-1:0] clr_addr;

  skt_ctrl #(
    .SETS (SETS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .clr_addr_o  (clr_addr)
  );

  skt_datapath #(
    .SETS        (SETS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .clr_addr_i    (clr_addr),
    .table_id_i    (table_id_i),
    .position_i    (position_i),
    .hit_o         (hit_o),
    .way_o         (way_o),
    .set_index_o   (set_index_o),
    .byte_offset_o (byte_offset_o)
  );

  // One transaction in flight: the input stalls right after an accept
  `SKT_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input accepted while a lookup is in flight")

  // A commit always presents a result in the next cycle
  `SKT_ASSERT_NEXT(a_commit_shows, clk_i, rst_ni, cmd.commit, out_valid_o, "commit did not present a result")

  // Clearing, reading and committing never overlap
  `SKT_ASSERT_NOW(a_cmd_exclusive, clk_i, rst_ni, 1'b1, $onehot0({cmd.rd_en, cmd.commit, cmd.clr_en}), "overlapping datapath commands")

endmodule

`default_nettype wire
